@@ rtl/cts_pkg.sv @@
// Shared types, token kind codes and the keyword table of the token scanner.
package cts_pkg;

  localparam int unsigned KwChars   = 8;
  localparam int unsigned KwCount   = 12;
  localparam int unsigned QueueDepth = 4;

  localparam logic [5:0] KindEnd    = 6'd0;
  localparam logic [5:0] KindDiv    = 6'd1;
  localparam logic [5:0] KindAssign = 6'd2;
  localparam logic [5:0] KindEq     = 6'd3;
  localparam logic [5:0] KindAdd    = 6'd4;
  localparam logic [5:0] KindSub    = 6'd5;
  localparam logic [5:0] KindNot    = 6'd6;
  localparam logic [5:0] KindNe     = 6'd7;
  localparam logic [5:0] KindLt     = 6'd8;
  localparam logic [5:0] KindLe     = 6'd9;
  localparam logic [5:0] KindShl    = 6'd10;
  localparam logic [5:0] KindGt     = 6'd11;
  localparam logic [5:0] KindGe     = 6'd12;
  localparam logic [5:0] KindShr    = 6'd13;
  localparam logic [5:0] KindBor    = 6'd14;
  localparam logic [5:0] KindLor    = 6'd15;
  localparam logic [5:0] KindBand   = 6'd16;
  localparam logic [5:0] KindLand   = 6'd17;
  localparam logic [5:0] KindXor    = 6'd18;
  localparam logic [5:0] KindMod    = 6'd19;
  localparam logic [5:0] KindMul    = 6'd20;
  localparam logic [5:0] KindLpar   = 6'd21;
  localparam logic [5:0] KindRpar   = 6'd22;
  localparam logic [5:0] KindLbrk   = 6'd23;
  localparam logic [5:0] KindRbrk   = 6'd24;
  localparam logic [5:0] KindLbrc   = 6'd25;
  localparam logic [5:0] KindRbrc   = 6'd26;
  localparam logic [5:0] KindBnot   = 6'd27;
  localparam logic [5:0] KindSemi   = 6'd28;
  localparam logic [5:0] KindColon  = 6'd29;
  localparam logic [5:0] KindComma  = 6'd30;
  localparam logic [5:0] KindKw0    = 6'd31;
  localparam logic [5:0] KindIdent  = 6'd43;
  localparam logic [5:0] KindNumber = 6'd44;

  typedef enum logic [16:0] {
    ModeIdle      = 17'h00001,
    ModeSlash     = 17'h00002,
    ModeLine      = 17'h00004,
    ModeBlock     = 17'h00008,
    ModeBlockStar = 17'h00010,
    ModeEq        = 17'h00020,
    ModeBang      = 17'h00040,
    ModeLt        = 17'h00080,
    ModeGt        = 17'h00100,
    ModeBar       = 17'h00200,
    ModeAmp       = 17'h00400,
    ModeIdent     = 17'h00800,
    ModeZero      = 17'h01000,
    ModeDec       = 17'h02000,
    ModeHex       = 17'h04000,
    ModeBin       = 17'h08000,
    ModeOct       = 17'h10000
  } scan_mode_e;

  // One token as it travels from the front end to the output stage.
  typedef struct packed {
    logic [5:0]               kind;
    logic                     is_name;
    logic [KwChars-1:0][7:0]  prefix;
    logic [31:0]              value;
    logic [15:0]              start;
    logic [15:0]              len;
    logic [15:0]              row;
    logic [15:0]              col;
    logic                     last;
  } tok_rec_t;

  typedef struct packed {
    logic [1:0] count;
    tok_rec_t   rec0;
    tok_rec_t   rec1;
  } tok_push_t;

  localparam logic [KwCount-1:0][63:0] KwText = {
    64'("get"), 64'("print"), 64'("return"), 64'("continue"),
    64'("break"), 64'("int"), 64'("for"), 64'("while"),
    64'("do"), 64'("case"), 64'("else"), 64'("if")
  };
  localparam logic [KwCount-1:0][3:0] KwLen = {
    4'd3, 4'd5, 4'd6, 4'd8, 4'd5, 4'd3, 4'd3, 4'd5, 4'd2, 4'd4, 4'd4, 4'd2
  };

  // Keyword kind for a name, or the identifier kind when nothing matches.
  function automatic logic [5:0] name_kind(logic [KwChars-1:0][7:0] pfx,
                                           logic [15:0] len);
    logic [5:0] k;
    logic       hit;
    logic [7:0] exp_ch;
    k = KindIdent;
    for (int i = KwCount - 1; i >= 0; i--) begin
      hit = (len == 16'(KwLen[i]));
      for (int j = 0; j < KwChars; j++) begin
        if (j < int'(KwLen[i])) begin
          exp_ch = KwText[i][8*(int'(KwLen[i]) - 1 - j) +: 8];
        end else begin
          exp_ch = 8'd0;
        end
        hit = hit && (pfx[j] == exp_ch);
      end
      if (hit) begin
        k = KindKw0 + 6'(i);
      end
    end
    return k;
  endfunction

endpackage

@@ rtl/cts_if.sv @@
// Handshake interfaces for source bytes and token beats.
interface cts_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] source_byte;
  modport source(output valid, output source_byte, input ready);
  modport sink(input valid, input source_byte, output ready);
endinterface

interface cts_tok_if;
  logic        valid;
  logic        ready;
  logic [5:0]  token_kind;
  logic [31:0] number_value;
  logic [15:0] ident_start;
  logic [15:0] ident_length;
  logic [15:0] token_row;
  logic [15:0] token_col;
  logic        last_of_run;
  modport source(output valid, output token_kind, output number_value,
                 output ident_start, output ident_length, output token_row,
                 output token_col, output last_of_run, input ready);
  modport sink(input valid, input token_kind, input number_value,
               input ident_start, input ident_length, input token_row,
               input token_col, input last_of_run, output ready);
endinterface

@@ rtl/cts_front.sv @@
// Front end: per-byte scan state machine that produces up to two token records.
module cts_front #(
  parameter int unsigned SOURCE_BYTES = 65536
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                accept_i,
  input  logic [7:0]          byte_i,
  output cts_pkg::tok_push_t  push_o
);
  import cts_pkg::*;

  localparam logic [15:0] OffCap =
    (SOURCE_BYTES - 1 < 65535) ? 16'(SOURCE_BYTES - 1) : 16'hFFFF;

  scan_mode_e              mode_q, mode_d;
  logic [31:0]             acc_q, acc_d;
  logic [KwChars-1:0][7:0] pfx_q, pfx_d;
  logic [15:0]             nlen_q, nlen_d, nstart_q, nstart_d, off_q, off_d;
  logic [15:0]             row_q, row_d, col_q, col_d, srow_q, srow_d, scol_q, scol_d;

  logic     cons, restart, c_emit, s_emit;
  tok_rec_t c_rec, s_rec;
  logic     is_alpha, is_digit, is_hex;
  logic [7:0] c;

  function automatic tok_rec_t mk(logic [5:0] k, logic [15:0] r, logic [15:0] cl);
    tok_rec_t t;
    t = '0;
    t.kind = k;
    t.row  = r;
    t.col  = cl;
    return t;
  endfunction

  always_comb begin
    c = byte_i;
    is_alpha = (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
    is_digit = (c >= "0" && c <= "9");
    is_hex   = is_digit || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
  end

  always_comb begin
    mode_d = ModeIdle;
    acc_d = acc_q; pfx_d = pfx_q; nlen_d = nlen_q; nstart_d = nstart_q;
    off_d = off_q; row_d = row_q; col_d = col_q; srow_d = srow_q; scol_d = scol_q;
    cons = 1'b1; restart = 1'b0;
    c_emit = 1'b0; s_emit = 1'b0;
    c_rec = mk(KindNumber, srow_q, scol_q);
    c_rec.value = acc_q;
    s_rec = mk(KindEnd, row_q, col_q);

    unique case (mode_q)
      ModeIdle: cons = 1'b0;
      ModeSlash: begin
        if (c == "/") begin
          mode_d = ModeLine;
        end else if (c == "*") begin
          mode_d = ModeBlock;
        end else begin
          c_emit = 1'b1; c_rec = mk(KindDiv, srow_q, scol_q); cons = 1'b0;
        end
      end
      ModeLine: begin
        if (c == 8'd0 || c == 8'h0A) begin
          cons = 1'b0;
        end else begin
          mode_d = ModeLine;
        end
      end
      ModeBlock, ModeBlockStar: begin
        if (c == 8'd0) begin
          cons = 1'b0;
        end else if (c == "*") begin
          mode_d = ModeBlockStar;
        end else if (c == "/" && mode_q == ModeBlockStar) begin
          mode_d = ModeIdle;
        end else begin
          mode_d = ModeBlock;
        end
      end
      ModeEq: begin
        c_emit = 1'b1;
        if (c == "=") begin
          c_rec = mk(KindEq, srow_q, scol_q);
        end else begin
          c_rec = mk(KindAssign, srow_q, scol_q); cons = 1'b0;
        end
      end
      ModeBang: begin
        c_emit = 1'b1;
        if (c == "=") begin
          c_rec = mk(KindNe, srow_q, scol_q);
        end else begin
          c_rec = mk(KindNot, srow_q, scol_q); cons = 1'b0;
        end
      end
      ModeLt: begin
        c_emit = 1'b1;
        if (c == "=") begin
          c_rec = mk(KindLe, srow_q, scol_q);
        end else if (c == "<") begin
          c_rec = mk(KindShl, srow_q, scol_q);
        end else begin
          c_rec = mk(KindLt, srow_q, scol_q); cons = 1'b0;
        end
      end
      ModeGt: begin
        c_emit = 1'b1;
        if (c == "=") begin
          c_rec = mk(KindGe, srow_q, scol_q);
        end else if (c == ">") begin
          c_rec = mk(KindShr, srow_q, scol_q);
        end else begin
          c_rec = mk(KindGt, srow_q, scol_q); cons = 1'b0;
        end
      end
      ModeBar: begin
        c_emit = 1'b1;
        if (c == "|") begin
          c_rec = mk(KindLor, srow_q, scol_q);
        end else begin
          c_rec = mk(KindBor, srow_q, scol_q); cons = 1'b0;
        end
      end
      ModeAmp: begin
        c_emit = 1'b1;
        if (c == "&") begin
          c_rec = mk(KindLand, srow_q, scol_q);
        end else begin
          c_rec = mk(KindBand, srow_q, scol_q); cons = 1'b0;
        end
      end
      ModeIdent: begin
        if (is_alpha || is_digit) begin
          if (nlen_q < 16'(KwChars)) begin
            pfx_d[nlen_q[$clog2(KwChars)-1:0]] = c;
          end
          if (nlen_q != 16'hFFFF) begin
            nlen_d = nlen_q + 16'd1;
          end
          mode_d = ModeIdent;
        end else begin
          c_emit = 1'b1; cons = 1'b0;
          c_rec = mk(KindIdent, srow_q, scol_q);
          c_rec.is_name = 1'b1;
          c_rec.prefix  = pfx_q;
          c_rec.start   = nstart_q;
          c_rec.len     = nlen_q;
        end
      end
      ModeDec: begin
        if (is_digit) begin
          acc_d = (acc_q << 3) + (acc_q << 1) + 32'(c - "0");
          mode_d = ModeDec;
        end else begin
          c_emit = 1'b1; cons = 1'b0;
        end
      end
      ModeHex: begin
        if (is_hex) begin
          acc_d = {acc_q[27:0], (c <= "9") ? 4'(c - "0") : 4'((c | 8'h20) - "a" + 8'd10)};
          mode_d = ModeHex;
        end else begin
          c_emit = 1'b1; cons = 1'b0;
        end
      end
      ModeBin: begin
        if (c == "0" || c == "1") begin
          acc_d = {acc_q[30:0], c[0]};
          mode_d = ModeBin;
        end else begin
          c_emit = 1'b1; cons = 1'b0;
        end
      end
      ModeZero, ModeOct: begin
        if (mode_q == ModeZero && (c == "x" || c == "X")) begin
          mode_d = ModeHex;
        end else if (mode_q == ModeZero && (c == "b" || c == "B")) begin
          mode_d = ModeBin;
        end else if (c >= "0" && c <= "7") begin
          acc_d = {acc_q[28:0], c[2:0]};
          mode_d = ModeOct;
        end else begin
          c_emit = 1'b1; cons = 1'b0;
        end
      end
      default: cons = 1'b0;
    endcase

    if (!cons) begin
      srow_d = row_q;
      scol_d = col_q;
      case (c)
        8'd0: begin
          s_emit = 1'b1; s_rec = mk(KindEnd, row_q, col_q); restart = 1'b1;
        end
        "/": mode_d = ModeSlash;
        "=": mode_d = ModeEq;
        "!": mode_d = ModeBang;
        "<": mode_d = ModeLt;
        ">": mode_d = ModeGt;
        "|": mode_d = ModeBar;
        "&": mode_d = ModeAmp;
        "+": begin s_emit = 1'b1; s_rec = mk(KindAdd, row_q, col_q); end
        "-": begin s_emit = 1'b1; s_rec = mk(KindSub, row_q, col_q); end
        "^": begin s_emit = 1'b1; s_rec = mk(KindXor, row_q, col_q); end
        "%": begin s_emit = 1'b1; s_rec = mk(KindMod, row_q, col_q); end
        "*": begin s_emit = 1'b1; s_rec = mk(KindMul, row_q, col_q); end
        "(": begin s_emit = 1'b1; s_rec = mk(KindLpar, row_q, col_q); end
        ")": begin s_emit = 1'b1; s_rec = mk(KindRpar, row_q, col_q); end
        "[": begin s_emit = 1'b1; s_rec = mk(KindLbrk, row_q, col_q); end
        "]": begin s_emit = 1'b1; s_rec = mk(KindRbrk, row_q, col_q); end
        "{": begin s_emit = 1'b1; s_rec = mk(KindLbrc, row_q, col_q); end
        "}": begin s_emit = 1'b1; s_rec = mk(KindRbrc, row_q, col_q); end
        "~": begin s_emit = 1'b1; s_rec = mk(KindBnot, row_q, col_q); end
        ";": begin s_emit = 1'b1; s_rec = mk(KindSemi, row_q, col_q); end
        ":": begin s_emit = 1'b1; s_rec = mk(KindColon, row_q, col_q); end
        ",": begin s_emit = 1'b1; s_rec = mk(KindComma, row_q, col_q); end
        default: begin
          if (is_alpha) begin
            pfx_d = '0;
            pfx_d[0] = c;
            nlen_d = 16'd1;
            nstart_d = off_q;
            mode_d = ModeIdent;
          end else if (is_digit) begin
            acc_d = 32'(c - "0");
            mode_d = (c == "0") ? ModeZero : ModeDec;
          end
        end
      endcase
    end

    if (restart) begin
      mode_d = ModeIdle; acc_d = '0; pfx_d = '0; nlen_d = '0; nstart_d = '0;
      off_d = '0; row_d = 16'd1; col_d = '0; srow_d = 16'd1; scol_d = '0;
    end else begin
      if (c == 8'h0A) begin
        if (row_q != 16'hFFFF) begin
          row_d = row_q + 16'd1;
        end
        col_d = '0;
      end else if (col_q != 16'hFFFF) begin
        col_d = col_q + 16'd1;
      end
      if (off_q < OffCap) begin
        off_d = off_q + 16'd1;
      end
    end
  end

  always_comb begin
    push_o = '0;
    if (accept_i) begin
      push_o.count = {1'b0, c_emit} + {1'b0, s_emit};
    end
    push_o.rec0 = c_emit ? c_rec : s_rec;
    push_o.rec1 = s_rec;
    if (c_emit && s_emit) begin
      push_o.rec1.last = 1'b1;
    end else begin
      push_o.rec0.last = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= ModeIdle; acc_q <= '0; pfx_q <= '0; nlen_q <= '0; nstart_q <= '0;
      off_q <= '0; row_q <= 16'd1; col_q <= '0; srow_q <= 16'd1; scol_q <= '0;
    end else if (accept_i) begin
      mode_q <= mode_d; acc_q <= acc_d; pfx_q <= pfx_d; nlen_q <= nlen_d;
      nstart_q <= nstart_d; off_q <= off_d; row_q <= row_d; col_q <= col_d;
      srow_q <= srow_d; scol_q <= scol_d;
    end
  end

endmodule

@@ rtl/cts_queue.sv @@
// Short token queue: takes up to two records per cycle, gives one.
module cts_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  cts_pkg::tok_push_t  push_i,
  input  logic                pop_i,
  output logic                has_room_o,
  output logic                not_empty_o,
  output cts_pkg::tok_rec_t   head_o
);
  import cts_pkg::*;

  localparam int unsigned PtrW = $clog2(QueueDepth);

  tok_rec_t          mem_q [QueueDepth];
  logic [PtrW-1:0]   wp_q, rp_q;
  logic [PtrW:0]     cnt_q;

  assign has_room_o  = cnt_q <= (PtrW + 1)'(QueueDepth - 2);
  assign not_empty_o = cnt_q != '0;
  assign head_o      = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push_i.count != 2'd0) begin
      mem_q[wp_q] <= push_i.rec0;
    end
    if (push_i.count == 2'd2) begin
      mem_q[wp_q + PtrW'(1)] <= push_i.rec1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0; rp_q <= '0; cnt_q <= '0;
    end else begin
      wp_q  <= wp_q + PtrW'(push_i.count);
      rp_q  <= rp_q + PtrW'(pop_i);
      cnt_q <= cnt_q + (PtrW + 1)'(push_i.count) - (PtrW + 1)'(pop_i);
    end
  end

endmodule

@@ rtl/cts_back.sv @@
// Back end: keyword lookup on names and the registered output beat.
module cts_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               not_empty_i,
  input  cts_pkg::tok_rec_t  head_i,
  output logic               pop_o,
  cts_tok_if.source          tok_o
);
  import cts_pkg::*;

  logic        valid_q;
  logic [5:0]  kind_q, kind_d;
  logic [31:0] value_q;
  logic [15:0] start_q, len_q, row_q, col_q;
  logic        last_q;

  assign pop_o = not_empty_i && (!valid_q || tok_o.ready);

  always_comb begin
    kind_d = head_i.kind;
    if (head_i.is_name) begin
      kind_d = name_kind(head_i.prefix, head_i.len);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (!valid_q || tok_o.ready) begin
      valid_q <= not_empty_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      kind_q  <= kind_d;
      value_q <= head_i.value;
      start_q <= (kind_d == KindIdent) ? head_i.start : '0;
      len_q   <= (kind_d == KindIdent) ? head_i.len : '0;
      row_q   <= head_i.row;
      col_q   <= head_i.col;
      last_q  <= head_i.last;
    end
  end

  assign tok_o.valid        = valid_q;
  assign tok_o.token_kind   = kind_q;
  assign tok_o.number_value = value_q;
  assign tok_o.ident_start  = start_q;
  assign tok_o.ident_length = len_q;
  assign tok_o.token_row    = row_q;
  assign tok_o.token_col    = col_q;
  assign tok_o.last_of_run  = last_q;

endmodule

@@ rtl/c_like_token_scanner_core.sv @@
// Top level of the C-like token scanner.
// The scanner takes one source byte per beat and can accept a byte in every
// cycle: the front end classifies the byte in the cycle it arrives and writes
// the zero, one or two tokens it finishes into a four-entry queue, and the back
// end resolves keywords and, while the sink is ready, presents one token beat
// per cycle from an output register. A token passes the queue and the output
// register before it appears. Input ready drops only while the queue holds
// more than two tokens, so the sustained input rate is one byte per cycle as
// long as the sink takes tokens at least as fast as they are made; the two
// tokens of one byte reach the sink one at a time. A zero byte ends a source,
// emits any pending token and then an end token, and resets row, column and
// byte offset for the next source. There is no clearing pass after reset.
module c_like_token_scanner_core #(
  parameter int unsigned SOURCE_BYTES = 65536
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  cts_byte_if.sink   src_i,
  cts_tok_if.source  tok_o
);
  import cts_pkg::*;

  tok_push_t push;
  tok_rec_t  head;
  logic      has_room, not_empty, pop, accept;

  // A byte is taken when the queue can absorb the two tokens it may cause.
  assign src_i.ready = has_room;
  assign accept      = src_i.valid && has_room;

  cts_front #(.SOURCE_BYTES(SOURCE_BYTES)) u_front (
    .clk_i, .rst_ni, .accept_i(accept), .byte_i(src_i.source_byte), .push_o(push)
  );

  cts_queue u_queue (
    .clk_i, .rst_ni, .push_i(push), .pop_i(pop), .has_room_o(has_room),
    .not_empty_o(not_empty), .head_o(head)
  );

  cts_back u_back (
    .clk_i, .rst_ni, .not_empty_i(not_empty), .head_i(head), .pop_o(pop), .tok_o(tok_o)
  );

endmodule

@@ rtl/cts_checker.sv @@
// Port-level checker for the token scanner and its bind statement.
module cts_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid,
  input logic        out_ready,
  input logic [5:0]  kind,
  input logic [31:0] value,
  input logic [15:0] istart,
  input logic [15:0] ilen,
  input logic [15:0] row,
  input logic        last
);
  import cts_pkg::*;

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(kind))
    else $error("token beat dropped while stalled");

  a_end_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && kind == KindEnd |-> last)
    else $error("end token not last of its byte");

  a_num_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && kind != KindNumber |-> value == '0)
    else $error("number value on non-number token");

  a_ident_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && kind != KindIdent |-> istart == '0 && ilen == '0)
    else $error("identifier fields on non-identifier token");

  a_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> row != '0)
    else $error("row zero on token");

endmodule

bind c_like_token_scanner_core cts_checker u_cts_checker (
  .clk_i(clk_i), .rst_ni(rst_ni), .out_valid(tok_o.valid), .out_ready(tok_o.ready),
  .kind(tok_o.token_kind), .value(tok_o.number_value), .istart(tok_o.ident_start),
  .ilen(tok_o.ident_length), .row(tok_o.token_row), .last(tok_o.last_of_run)
);
